// File: hw/rtl/line_message_byte_buffer_defines.svh
// ---------------------------------------------------------------------------
// line_message_byte_buffer_defines
// assertion macros used by the checker file of the byte buffer
// ---------------------------------------------------------------------------
`ifndef LINE_MESSAGE_BYTE_BUFFER_DEFINES_SVH
`define LINE_MESSAGE_BYTE_BUFFER_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define LMBB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge out of reset
`define LMBB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/lmbb_pkg.sv
// ---------------------------------------------------------------------------
// lmbb_pkg
// constants, types and helpers of the line message byte buffer
// ---------------------------------------------------------------------------
package lmbb_pkg;

    // buffer geometry
    localparam int DEPTH  = 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PTR_W  = $clog2(DEPTH + 1);

    // field widths
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 9;

    // request codes
    localparam logic REQ_PUT = 1'b0;
    localparam logic REQ_GET = 1'b1;

    // message delimiters
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_NUL     = 8'h00;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    function automatic logic is_delim(input logic [BYTE_W-1:0] b);
        return (b == CH_NEWLINE) || (b == CH_NUL);
    endfunction

endpackage

// File: hw/rtl/lmbb_ram.sv
// ---------------------------------------------------------------------------
// lmbb_ram
// generic single-write, single-read synchronous ram with registered read
// ---------------------------------------------------------------------------
module lmbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hw/rtl/line_message_byte_buffer.sv
// ---------------------------------------------------------------------------
// line_message_byte_buffer
// linear byte buffer for line-delimited messages with a message count
// ---------------------------------------------------------------------------
// done: the strobe is registered from the execute state that follows the
//   accept; busy holds off a new request until that state is over, set by the
//   read of the byte ram followed by the update of pointers and count
// reset: pointers and message count clear at once, the ram is not cleared;
//   a get on an empty buffer reads it but returns no byte; busy is low right after reset
module line_message_byte_buffer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         req_type,
    input  logic [lmbb_pkg::BYTE_W-1:0]  byte_in,
    output logic                         done,
    output logic [lmbb_pkg::BYTE_W-1:0]  read_byte,
    output logic                         read_valid,
    output logic                         put_dropped,
    output logic [lmbb_pkg::CNT_W-1:0]   message_count,
    output logic [lmbb_pkg::CNT_W-1:0]   bytes_held
);

    lmbb_pkg::state_t                  state_reg, state_next;
    logic [lmbb_pkg::PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [lmbb_pkg::PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [lmbb_pkg::PTR_W-1:0]        msgs_reg, msgs_next;
    logic                              done_reg;
    logic                              req_type_reg;
    logic [lmbb_pkg::BYTE_W-1:0]       req_byte_reg;
    logic [lmbb_pkg::BYTE_W-1:0]       read_byte_reg, read_byte_next;
    logic                              read_valid_reg, read_valid_next;
    logic                              put_dropped_reg, put_dropped_next;
    logic [lmbb_pkg::CNT_W-1:0]        message_count_reg, message_count_next;
    logic [lmbb_pkg::CNT_W-1:0]        bytes_held_reg, bytes_held_next;

    logic                              accept;
    logic                              exec;
    logic                              full;
    logic [lmbb_pkg::PTR_W-1:0]        wr_inc;
    logic [lmbb_pkg::PTR_W-1:0]        rd_inc;
    logic [lmbb_pkg::BYTE_W-1:0]       ram_rdata;
    logic                              ram_we;
    logic                              ram_re;

    assign accept = start && (state_reg == lmbb_pkg::ST_IDLE);
    assign exec   = (state_reg == lmbb_pkg::ST_EXEC);
    assign full   = (wr_ptr_reg == lmbb_pkg::PTR_W'(lmbb_pkg::DEPTH));
    assign wr_inc = wr_ptr_reg + lmbb_pkg::PTR_W'(1);
    assign rd_inc = rd_ptr_reg + lmbb_pkg::PTR_W'(1);

    // byte store: read issued on accept, write done in the execute cycle
    assign ram_re = accept && (req_type == lmbb_pkg::REQ_GET);
    assign ram_we = exec && (req_type_reg == lmbb_pkg::REQ_PUT) && !full;

    lmbb_ram #(
        .WIDTH (lmbb_pkg::BYTE_W),
        .DEPTH (lmbb_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg[lmbb_pkg::ADDR_W-1:0]),
        .wdata (req_byte_reg),
        .re    (ram_re),
        .raddr (rd_ptr_reg[lmbb_pkg::ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lmbb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = lmbb_pkg::ST_EXEC;
                end
            end
            lmbb_pkg::ST_EXEC:
            begin
                state_next = lmbb_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lmbb_pkg::ST_IDLE;
            end
        endcase
    end

    // pointer, count and result update for the request in flight
    always_comb
    begin
        logic [lmbb_pkg::BYTE_W-1:0] rbyte;
        rbyte            = ram_rdata;
        wr_ptr_next      = wr_ptr_reg;
        rd_ptr_next      = rd_ptr_reg;
        msgs_next        = msgs_reg;
        read_byte_next   = '0;
        read_valid_next  = 1'b0;
        put_dropped_next = 1'b0;

        if (req_type_reg == lmbb_pkg::REQ_PUT)
        begin
            if (full)
            begin
                put_dropped_next = 1'b1;
            end
            else
            begin
                wr_ptr_next = wr_inc;
                // delimiter or forced end in the last slot
                if (lmbb_pkg::is_delim(req_byte_reg) ||
                    (wr_inc == lmbb_pkg::PTR_W'(lmbb_pkg::DEPTH)))
                begin
                    msgs_next = msgs_reg + lmbb_pkg::PTR_W'(1);
                end
            end
        end
        else if (rd_ptr_reg < wr_ptr_reg)
        begin
            // final byte of a full buffer reads back as newline
            if (full && (rd_inc == lmbb_pkg::PTR_W'(lmbb_pkg::DEPTH)))
            begin
                rbyte = lmbb_pkg::CH_NEWLINE;
            end
            read_byte_next  = rbyte;
            read_valid_next = 1'b1;
            rd_ptr_next     = rd_inc;
            if (lmbb_pkg::is_delim(rbyte) && (msgs_reg != '0))
            begin
                msgs_next = msgs_reg - lmbb_pkg::PTR_W'(1);
            end
            // drained: rewind both pointers
            if (rd_inc == wr_ptr_reg)
            begin
                rd_ptr_next = '0;
                wr_ptr_next = '0;
            end
        end

        message_count_next = lmbb_pkg::CNT_W'(msgs_next);
        bytes_held_next    = lmbb_pkg::CNT_W'(wr_ptr_next - rd_ptr_next);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lmbb_pkg::ST_IDLE;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            msgs_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= exec;
            if (exec)
            begin
                wr_ptr_reg <= wr_ptr_next;
                rd_ptr_reg <= rd_ptr_next;
                msgs_reg   <= msgs_next;
            end
        end
    end

    // request capture and result registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg <= req_type;
            req_byte_reg <= byte_in;
        end
        if (exec)
        begin
            read_byte_reg     <= read_byte_next;
            read_valid_reg    <= read_valid_next;
            put_dropped_reg   <= put_dropped_next;
            message_count_reg <= message_count_next;
            bytes_held_reg    <= bytes_held_next;
        end
    end

    assign busy          = (state_reg != lmbb_pkg::ST_IDLE);
    assign done          = done_reg;
    assign read_byte     = read_byte_reg;
    assign read_valid    = read_valid_reg;
    assign put_dropped   = put_dropped_reg;
    assign message_count = message_count_reg;
    assign bytes_held    = bytes_held_reg;

endmodule

// File: hw/rtl/lmbb_checker.sv
// ---------------------------------------------------------------------------
// lmbb_checker
// port-level timing checks of the line message byte buffer
// ---------------------------------------------------------------------------
`include "line_message_byte_buffer_defines.svh"

module lmbb_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // an accepted request raises busy in the following cycle, holding off the next one
    `LMBB_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "busy not raised after request")

    // every accepted request gives a done strobe after its execute state
    `LMBB_ASSERT_NEXT(a_done_after_accept, start && !busy, ##1 done, "missing done strobe")

    // the done strobe comes when the block is free again
    `LMBB_ASSERT_NOW(a_done_not_busy, done, !busy, "done while busy")

    // a strobe is never issued without a request in flight
    `LMBB_ASSERT_NEXT(a_done_needs_busy, !busy, !done, "done without a request")

endmodule

bind line_message_byte_buffer lmbb_checker u_lmbb_checker (.*);
